// ===== hw/rtl/vvdc_pkg.sv =====
package vvdc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ScreenW = 28;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned ViewW = 13;
  localparam int unsigned QuotW = 29;

  localparam logic [CfgIdxW-1:0] RegRow0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWidth = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
    logic signed [CoordW-1:0] vertex_w;
    logic                     batch_last;
  } vertex_in_t;

  typedef struct packed {
    logic [ScreenW-1:0]       screen_x;
    logic [ScreenW-1:0]       screen_y;
    logic signed [CoordW-1:0] depth;
    logic signed [CoordW-1:0] clip_w;
    logic                     divide_by_zero;
    logic                     batch_end;
  } vertex_out_t;

endpackage

// ===== hw/rtl/vvdc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Computes (num << 16) / den for unsigned magnitudes.
module vvdc_div (
  input  logic                       clk_i,
  input  logic [31:0]                num_i,
  input  logic [31:0]                den_i,
  output logic [vvdc_pkg::QuotW-1:0] quot_o
);
  import vvdc_pkg::*;

  // Integer part limited to 13 bits (overflow folded into an extra top flag).
  localparam int unsigned Steps = QuotW;

  logic [47:0]      rem_q [Steps-1];
  logic [31:0]      den_q [Steps-1];
  logic [QuotW-1:0] quo_q [Steps];
  logic             ovf_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    localparam int unsigned Sh = Steps - 1 - s;
    logic [47:0]      rem_in;
    logic [31:0]      den_in;
    logic [QuotW-1:0] quo_in;
    logic             ovf_in;
    logic [80:0]      trial;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = {num_i, 16'd0};
      assign den_in = den_i;
      assign quo_in = '0;
      // quotient >= 2^29 means integer part >= 8192 > limit
      assign ovf_in = (num_i >> 13) >= den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    assign trial = {49'd0, den_in} << Sh;
    assign take = {33'd0, rem_in} >= trial;

    if (s < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= take ? rem_in - trial[47:0] : rem_in;
        den_q[s] <= den_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[s] <= quo_in | (QuotW'(take) << Sh);
      ovf_q[s] <= ovf_in;
    end
  end

  assign quot_o = ovf_q[Steps-1] ? '1 : quo_q[Steps-1];
endmodule

// ===== hw/rtl/vertex_view_divide_clamp_top.sv =====
// Vertex view transform, perspective divide and viewport clamp. One vertex
// may be started every cycle; each gives one result beat on done_o after 3
// transform stages, 29 divider stages and one output register. The
// receiver cannot stall; results are never dropped.
module vertex_view_divide_clamp_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  vvdc_pkg::vertex_in_t              vertex_i,
  output logic                              done_o,
  output vvdc_pkg::vertex_out_t             result_o,
  input  logic                              cfg_we_i,
  input  logic [vvdc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [vvdc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import vvdc_pkg::*;

  logic [63:0]      row_q [4];
  logic [ViewW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'd4096;
      row_q[1] <= 64'd4096 << 16;
      row_q[2] <= 64'd4096 << 32;
      row_q[3] <= 64'd4096 << 48;
      width_q <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRow0: row_q[0] <= cfg_data_i;
        RegRow1: row_q[1] <= cfg_data_i;
        RegRow2: row_q[2] <= cfg_data_i;
        RegRow3: row_q[3] <= cfg_data_i;
        RegWidth: width_q <= cfg_data_i[ViewW-1:0];
        RegHeight: height_q <= cfg_data_i[ViewW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: sixteen products
  logic               v1_q;
  logic signed [47:0] p1_q [4][4];
  logic               last1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      p1_q[r][0] <= $signed(row_q[r][15:0]) * vertex_i.vertex_x;
      p1_q[r][1] <= $signed(row_q[r][31:16]) * vertex_i.vertex_y;
      p1_q[r][2] <= $signed(row_q[r][47:32]) * vertex_i.vertex_z;
      p1_q[r][3] <= $signed(row_q[r][63:48]) * vertex_i.vertex_w;
    end
    last1_q <= vertex_i.batch_last;
  end

  // Stage 2: sums (exact, since rounding of the exact sum equals model's)
  logic               v2_q, last2_q;
  logic signed [49:0] s2_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++)
      s2_q[r] <= 50'(p1_q[r][0]) + 50'(p1_q[r][1]) + 50'(p1_q[r][2]) + 50'(p1_q[r][3])
                 + 50'sd2048;
    last2_q <= last1_q;
  end

  // Stage 3: round, saturate, sign handling for the divider
  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    if (v > 39'sd2147483647) return 32'sh7fffffff;
    if (v < -39'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [31:0] t3 [4];
  always_comb
    for (int r = 0; r < 4; r++) t3[r] = sat32(39'(s2_q[r] >>> 12));

  typedef struct packed {
    logic        zx;
    logic        zy;
    logic        zw;
    logic [31:0] depth;
    logic [31:0] clipw;
    logic        last;
    logic [ViewW-1:0] wd;
    logic [ViewW-1:0] ht;
  } tag_t;

  logic [31:0] ax, ay, aw;
  tag_t        tg;
  logic signed [32:0] negz;
  always_comb begin
    negz = -33'(t3[2]);
    ax = t3[0][31] ? 32'(-33'(t3[0])) : t3[0];
    ay = t3[1][31] ? 32'(-33'(t3[1])) : t3[1];
    aw = t3[3][31] ? 32'(-33'(t3[3])) : t3[3];
    tg.zw = (t3[3] == 0);
    tg.zx = (t3[0] == 0) || (t3[0][31] != t3[3][31]) || tg.zw;
    tg.zy = (t3[1] == 0) || (t3[1][31] != t3[3][31]) || tg.zw;
    tg.depth = (negz > 33'sd2147483647) ? 32'h7fffffff : negz[31:0];
    tg.clipw = t3[3];
    tg.last = last2_q;
    tg.wd = width_q;
    tg.ht = height_q;
  end

  logic        v3_q;
  logic [31:0] ax_q, ay_q, aw_q;
  tag_t        tg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    ax_q <= ax;
    ay_q <= ay;
    aw_q <= tg.zw ? 32'd1 : aw;
    tg_q <= tg;
  end

  logic [QuotW-1:0] qx, qy;

  vvdc_div u_div_x (
    .clk_i, .num_i(ax_q), .den_i(aw_q), .quot_o(qx)
  );
  vvdc_div u_div_y (
    .clk_i, .num_i(ay_q), .den_i(aw_q), .quot_o(qy)
  );

  // Carry the side fields alongside the divider stages.
  tag_t tag_pipe_q [QuotW];
  tag_t tgx;
  always_ff @(posedge clk_i) begin
    tag_pipe_q[0] <= tg_q;
    for (int i = 1; i < QuotW; i++) tag_pipe_q[i] <= tag_pipe_q[i-1];
  end
  assign tgx = tag_pipe_q[QuotW-1];

  // Divider valid tracked separately so it is reset.
  logic [QuotW-1:0] vpipe_q;
  logic             tv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vpipe_q <= '0;
    else vpipe_q <= {vpipe_q[QuotW-2:0], v3_q};
  end
  assign tv = vpipe_q[QuotW-1];

  function automatic logic [ScreenW-1:0] clampq(input logic [QuotW-1:0] q,
                                                input logic [ViewW-1:0] sz,
                                                input logic zero);
    logic [12:0] s;
    logic [28:0] lim;
    s = (sz > 13'd4096) ? 13'd4096 : sz;
    lim = (s == 0) ? 29'd0 : 29'({16'd0, s - 13'd1}) << 16;
    if (zero) return '0;
    return (q > lim) ? lim[ScreenW-1:0] : q[ScreenW-1:0];
  endfunction

  logic        done_q;
  vertex_out_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= tv;
  end
  always_ff @(posedge clk_i) begin
    res_q.screen_x <= clampq(qx, tgx.wd, tgx.zx);
    res_q.screen_y <= clampq(qy, tgx.ht, tgx.zy);
    res_q.depth <= tgx.depth;
    res_q.clip_w <= tgx.clipw;
    res_q.divide_by_zero <= tgx.zw;
    res_q.batch_end <= tgx.last;
  end

  assign done_o = done_q;
  assign result_o = res_q;
endmodule

// ===== hw/rtl/vvdc_checker.sv =====
module vvdc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input vvdc_pkg::vertex_out_t result_o
);
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##33 done_o)
    else $error("result beat missing after start");
  a_zero_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.divide_by_zero |-> result_o.screen_x == 0 && result_o.screen_y == 0)
    else $error("zero w with nonzero screen");
  a_zero_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.divide_by_zero |-> result_o.clip_w == 0)
    else $error("flag without zero w");
  a_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.screen_x <= 28'd268369920 && result_o.screen_y <= 28'd268369920)
    else $error("screen out of range");
endmodule

bind vertex_view_divide_clamp_top vvdc_checker u_vvdc_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .result_o
);
